/* sv/sphere_box_contact_top_assert.svh */
// Assertion macros for the sphere and box contact block.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef SPHERE_BOX_CONTACT_TOP_ASSERT_SVH
`define SPHERE_BOX_CONTACT_TOP_ASSERT_SVH

// Same-cycle implication, gated by reset
`define SBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sphere_box_contact: check failed");

// Next-cycle implication, gated by reset
`define SBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sphere_box_contact: check failed");

`endif

/* sv/sbc_pkg.sv */
// Shared types, constants and arithmetic helpers for the sphere and box contact block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbc_pkg;

  // Matrix entry width (Q20 rotation matrix, non-unit quaternions included)
  localparam int M_W        = 26;
  localparam int SQ_STAGES  = 16;
  localparam int DIV_STAGES = 5;
  localparam int DIV_STEPS  = 3;
  localparam int Q_W        = 15;
  localparam int REM_W      = 46;

  localparam logic signed [15:0] NORM_ONE = 16'sd16384;

  typedef enum logic [1:0] {
    CFG_HALF_X = 2'd0,
    CFG_HALF_Y = 2'd1,
    CFG_HALF_Z = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_e;

  typedef struct packed {
    logic signed [31:0] sphere_x;
    logic signed [31:0] sphere_y;
    logic signed [31:0] sphere_z;
    logic        [30:0] sphere_radius;
    logic signed [31:0] box_x;
    logic signed [31:0] box_y;
    logic signed [31:0] box_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [30:0] penetration;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } out_t;

  // Per-item context carried along the pipeline
  typedef struct packed {
    logic [2:0][31:0]    s;
    logic [30:0]         r;
    logic [8:0][M_W-1:0] m;
    logic                miss;
    axis_e               axis;
    logic                apos;
    logic [2:0]          neg;
    logic [2:0][30:0]    mag;
  } ctx_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
  } sq_acc_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   q;
  } dv_acc_t;

  // Round a Q28 matrix entry to Q20, halves up
  function automatic logic signed [M_W-1:0] rnd_m(logic signed [33:0] v);
    logic signed [33:0] t;
    t = v + 34'sd128;
    return $signed(t[33:8]);
  endfunction

  // One bit of the floored square root
  function automatic sq_acc_t sq_step(sq_acc_t a, logic [1:0] b);
    logic [34:0] cur;
    logic [34:0] t;
    sq_acc_t     o;
    cur = {a.rem[32:0], b};
    t   = {1'b0, a.root, 2'b01};
    if (cur >= t) begin
      o.rem  = cur - t;
      o.root = {a.root[30:0], 1'b1};
    end else begin
      o.rem  = cur;
      o.root = {a.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit of the restoring divider
  function automatic dv_acc_t div_step(dv_acc_t a, logic [31:0] dvsr, int k);
    logic [REM_W-1:0] sub;
    dv_acc_t          o;
    sub = REM_W'(dvsr) << k;
    o   = a;
    if (a.rem >= sub) begin
      o.rem = a.rem - sub;
      o.q   = a.q | (Q_W'(1) << k);
    end
    return o;
  endfunction

endpackage

`default_nettype wire

/* sv/sbc_sqrt.sv */
// Pipelined floored square root, two result bits per stage.
// Depends on sbc_pkg (ctx_t, sq_step).
`timescale 1ns / 1ps
`default_nettype none

module sbc_sqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [63:0]   in_x,
  input  sbc_pkg::ctx_t in_ctx,
  output logic          out_v,
  output logic [31:0]   out_root,
  output sbc_pkg::ctx_t out_ctx
);

  localparam int NS = sbc_pkg::SQ_STAGES;

  logic              v_r     [NS];
  logic [63:0]       x_r     [NS];
  sbc_pkg::sq_acc_t  acc_r   [NS];
  sbc_pkg::ctx_t     ctx_r   [NS];
  logic [63:0]       x_src   [NS];
  sbc_pkg::sq_acc_t  a_src   [NS];
  sbc_pkg::sq_acc_t  a_mid   [NS];
  sbc_pkg::sq_acc_t  acc_nxt [NS];

  // Two root bits per stage, radicand consumed from the top
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        x_src[k] = in_x;
        a_src[k] = '0;
      end else begin
        x_src[k] = x_r[k-1];
        a_src[k] = acc_r[k-1];
      end
      a_mid[k]   = sbc_pkg::sq_step(a_src[k], x_src[k][63:62]);
      acc_nxt[k] = sbc_pkg::sq_step(a_mid[k], x_src[k][61:60]);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int k = 1; k < NS; k++) v_r[k] <= v_r[k-1];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        x_r[k]   <= {x_src[k][59:0], 4'b0000};
        acc_r[k] <= acc_nxt[k];
        ctx_r[k] <= (k == 0) ? in_ctx : ctx_r[k-1];
      end
    end
  end

  assign out_v    = v_r[NS-1];
  assign out_root = acc_r[NS-1].root;
  assign out_ctx  = ctx_r[NS-1];

endmodule

`default_nettype wire

/* sv/sbc_div.sv */
// Pipelined three-lane restoring divider for the local normal (|delta| * 2^14 / dist).
// Depends on sbc_pkg (ctx_t, div_step).
`timescale 1ns / 1ps
`default_nettype none

module sbc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_v,
  input  logic [31:0]                     in_dist,
  input  sbc_pkg::ctx_t                   in_ctx,
  output logic                            out_v,
  output logic [31:0]                     out_dist,
  output sbc_pkg::ctx_t                   out_ctx,
  output logic [2:0][sbc_pkg::Q_W-1:0]    out_q
);

  localparam int NS = sbc_pkg::DIV_STAGES;
  localparam int NT = sbc_pkg::DIV_STEPS;
  localparam int QW = sbc_pkg::Q_W;
  localparam int RW = sbc_pkg::REM_W;

  logic              v_r     [NS];
  logic [31:0]       dist_r  [NS];
  sbc_pkg::ctx_t     ctx_r   [NS];
  sbc_pkg::dv_acc_t  acc_r   [NS][3];
  logic [31:0]       d_src   [NS];
  sbc_pkg::dv_acc_t  acc_nxt [NS][3];

  // Three quotient bits per stage and lane, rounding offset folded into the dividend
  always_comb begin
    sbc_pkg::dv_acc_t a;
    for (int k = 0; k < NS; k++) begin
      d_src[k] = (k == 0) ? in_dist : dist_r[k-1];
      for (int l = 0; l < 3; l++) begin
        if (k == 0) begin
          a.rem = RW'({in_ctx.mag[l], 14'b0}) + RW'(in_dist[31:1]);
          a.q   = '0;
        end else begin
          a = acc_r[k-1][l];
        end
        for (int t = 0; t < NT; t++) begin
          a = sbc_pkg::div_step(a, d_src[k], QW - 1 - (k * NT + t));
        end
        acc_nxt[k][l] = a;
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int k = 1; k < NS; k++) v_r[k] <= v_r[k-1];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        dist_r[k] <= d_src[k];
        ctx_r[k]  <= (k == 0) ? in_ctx : ctx_r[k-1];
        for (int l = 0; l < 3; l++) acc_r[k][l] <= acc_nxt[k][l];
      end
    end
  end

  assign out_v    = v_r[NS-1];
  assign out_dist = dist_r[NS-1];
  assign out_ctx  = ctx_r[NS-1];
  always_comb begin
    for (int l = 0; l < 3; l++) out_q[l] = acc_r[NS-1][l].q;
  end

endmodule

`default_nettype wire

/* sv/sphere_box_contact_top.sv */
// Sphere versus oriented box contact test, top level and pipeline.
// Depends on sbc_pkg, sbc_sqrt, sbc_div and sphere_box_contact_top_assert.svh.
//
//  channel | ports                         | payload
//  --------+-------------------------------+-----------------------------
//  input   | in_valid / in_ready           | in_data  (sbc_pkg::in_t)
//  result  | out_valid / out_ready         | out_data (sbc_pkg::out_t)
//  config  | cfg_valid / cfg_ready         | cfg_index, cfg_data[30:0]
//
// One item enters per cycle unless the result register is held.
// The pipeline runs through the 16-stage square root and the 5-stage divider.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) clears valid bits and sets half extents to 1.0.
`timescale 1ns / 1ps
`default_nettype none
`include "sphere_box_contact_top_assert.svh"

module sphere_box_contact_top #(
  parameter int LENGTH_FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sbc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sbc_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int MW = sbc_pkg::M_W;
  localparam logic [30:0] HALF_RESET = 31'(64'd1 << LENGTH_FRAC_BITS);
  localparam logic signed [34:0] PT_MAX = 35'sd2147483647;
  localparam logic signed [34:0] PT_MIN = -35'sd2147483648;
  localparam logic signed [23:0] NW_MAX = 24'sd16384;

  logic        pipe_en;
  logic [30:0] h_r [3];

  // Stage registers
  logic                v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  sbc_pkg::ctx_t       c1_r, c2_r, c3_r, c4_r, c5_r, c6_r, c7_r;
  sbc_pkg::ctx_t       c1_nxt, c5_nxt, c7_nxt;
  logic signed [32:0]  d1_r [3];
  logic signed [32:0]  d1_nxt [3];
  logic signed [58:0]  prod2_r [9];
  logic signed [58:0]  prod2_nxt [9];
  logic signed [40:0]  p3_r [3];
  logic signed [40:0]  p3_nxt [3];
  logic signed [41:0]  dl4_r [3];
  logic signed [41:0]  dl4_nxt [3];
  logic [41:0]         absp4_r [3];
  logic [41:0]         absp4_nxt [3];
  logic [2:0]          ppos4_r, ppos4_nxt;
  logic [61:0]         sq6_r [3];
  logic [61:0]         sq6_nxt [3];
  logic [61:0]         rsq6_r, rsq6_nxt;
  logic [63:0]         dsq7_r, dsq7_nxt;

  logic                sq_v;
  logic [31:0]         sq_root;
  sbc_pkg::ctx_t       sq_ctx;
  logic                dv_v;
  logic [31:0]         dv_dist;
  sbc_pkg::ctx_t       dv_ctx;
  logic [2:0][sbc_pkg::Q_W-1:0] dv_q;

  logic                w1_v_r, w2_v_r, p1_v_r, out_valid_r;
  sbc_pkg::ctx_t       w1_c_r, w2_c_r, p1_c_r;
  logic [31:0]         w1_dist_r, w2_dist_r;
  logic signed [41:0]  wp1_r [9];
  logic signed [41:0]  wp1_nxt [9];
  logic signed [15:0]  nw2_r [3];
  logic signed [15:0]  nw2_nxt [3];
  logic signed [47:0]  pr1_r [3];
  logic signed [47:0]  pr1_nxt [3];
  logic signed [15:0]  nwp1_r [3];
  logic [30:0]         pen1_r, pen1_nxt;
  sbc_pkg::out_t       out_data_r, out_data_nxt;

  // Whole pipeline moves unless the result register is held
  assign pipe_en   = !out_valid_r || out_ready;
  assign in_ready  = pipe_en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) h_r[k] <= HALF_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sbc_pkg::CFG_HALF_X: h_r[0] <= cfg_data[30:0];
        sbc_pkg::CFG_HALF_Y: h_r[1] <= cfg_data[30:0];
        sbc_pkg::CFG_HALF_Z: h_r[2] <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Stage 1: offset and rotation matrix from the quaternion
  always_comb begin
    logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
    logic signed [33:0] one28;
    logic signed [33:0] mraw [9];
    pxx = in_data.quat_x * in_data.quat_x;
    pyy = in_data.quat_y * in_data.quat_y;
    pzz = in_data.quat_z * in_data.quat_z;
    pxy = in_data.quat_x * in_data.quat_y;
    pxz = in_data.quat_x * in_data.quat_z;
    pyz = in_data.quat_y * in_data.quat_z;
    pwx = in_data.quat_w * in_data.quat_x;
    pwy = in_data.quat_w * in_data.quat_y;
    pwz = in_data.quat_w * in_data.quat_z;
    one28 = 34'sd268435456;
    mraw[0] = one28 - (34'(pyy) <<< 1) - (34'(pzz) <<< 1);
    mraw[1] = (34'(pxy) - 34'(pwz)) <<< 1;
    mraw[2] = (34'(pxz) + 34'(pwy)) <<< 1;
    mraw[3] = (34'(pxy) + 34'(pwz)) <<< 1;
    mraw[4] = one28 - (34'(pxx) <<< 1) - (34'(pzz) <<< 1);
    mraw[5] = (34'(pyz) - 34'(pwx)) <<< 1;
    mraw[6] = (34'(pxz) - 34'(pwy)) <<< 1;
    mraw[7] = (34'(pyz) + 34'(pwx)) <<< 1;
    mraw[8] = one28 - (34'(pxx) <<< 1) - (34'(pyy) <<< 1);
    c1_nxt      = '0;
    c1_nxt.s[0] = in_data.sphere_x;
    c1_nxt.s[1] = in_data.sphere_y;
    c1_nxt.s[2] = in_data.sphere_z;
    c1_nxt.r    = in_data.sphere_radius;
    for (int k = 0; k < 9; k++) c1_nxt.m[k] = sbc_pkg::rnd_m(mraw[k]);
    d1_nxt[0] = 33'(in_data.sphere_x) - 33'(in_data.box_x);
    d1_nxt[1] = 33'(in_data.sphere_y) - 33'(in_data.box_y);
    d1_nxt[2] = 33'(in_data.sphere_z) - 33'(in_data.box_z);
  end

  // Stage 2: transposed matrix times offset, one product per entry
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod2_nxt[i*3+j] = $signed(c1_r.m[j*3+i]) * d1_r[j];
      end
    end
  end

  // Stage 3: sum and round to Q16.16
  always_comb begin
    logic signed [60:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = 61'(prod2_r[i*3]) + 61'(prod2_r[i*3+1]) + 61'(prod2_r[i*3+2])
            + (61'sd1 <<< 19);
      p3_nxt[i] = $signed(acc[60:20]);
    end
  end

  // Stage 4: clamp to the box and take the delta
  always_comb begin
    logic signed [41:0] hs, pe, cl;
    for (int i = 0; i < 3; i++) begin
      hs = $signed({11'b0, h_r[i]});
      pe = 42'(p3_r[i]);
      if (pe < -hs) begin
        cl = -hs;
      end else if (pe > hs) begin
        cl = hs;
      end else begin
        cl = pe;
      end
      dl4_nxt[i]   = pe - cl;
      absp4_nxt[i] = pe[41] ? 42'(-pe) : 42'(pe);
      ppos4_nxt[i] = !pe[41] && (pe != '0);
    end
  end

  // Stage 5: per-axis miss, magnitudes and axis of least depth
  always_comb begin
    logic [41:0]        absdl;
    logic [2:0]         ax_miss;
    logic signed [42:0] dep [3];
    c5_nxt = c4_r;
    for (int i = 0; i < 3; i++) begin
      absdl         = dl4_r[i][41] ? 42'(-dl4_r[i]) : 42'(dl4_r[i]);
      ax_miss[i]    = absdl >= {11'b0, c4_r.r};
      c5_nxt.neg[i] = dl4_r[i][41];
      c5_nxt.mag[i] = absdl[30:0];
      dep[i]        = $signed({12'b0, h_r[i]}) - $signed({1'b0, absp4_r[i]});
    end
    c5_nxt.miss = |ax_miss;
    if (dep[0] < dep[1] && dep[0] < dep[2]) begin
      c5_nxt.axis = sbc_pkg::AX_X;
      c5_nxt.apos = ppos4_r[0];
    end else if (dep[1] < dep[2]) begin
      c5_nxt.axis = sbc_pkg::AX_Y;
      c5_nxt.apos = ppos4_r[1];
    end else begin
      c5_nxt.axis = sbc_pkg::AX_Z;
      c5_nxt.apos = ppos4_r[2];
    end
  end

  // Stage 6: squares
  always_comb begin
    for (int i = 0; i < 3; i++) sq6_nxt[i] = 62'(c5_r.mag[i]) * 62'(c5_r.mag[i]);
    rsq6_nxt = 62'(c5_r.r) * 62'(c5_r.r);
  end

  // Stage 7: squared distance and overall miss
  always_comb begin
    dsq7_nxt    = 64'(sq6_r[0]) + 64'(sq6_r[1]) + 64'(sq6_r[2]);
    c7_nxt      = c6_r;
    c7_nxt.miss = c6_r.miss || (dsq7_nxt >= 64'(rsq6_r));
  end

  // Advance valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  // Advance payload of the front stages
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      c1_r    <= c1_nxt;
      d1_r    <= d1_nxt;
      c2_r    <= c1_r;
      prod2_r <= prod2_nxt;
      c3_r    <= c2_r;
      p3_r    <= p3_nxt;
      c4_r    <= c3_r;
      dl4_r   <= dl4_nxt;
      absp4_r <= absp4_nxt;
      ppos4_r <= ppos4_nxt;
      c5_r    <= c5_nxt;
      c6_r    <= c5_r;
      sq6_r   <= sq6_nxt;
      rsq6_r  <= rsq6_nxt;
      c7_r    <= c7_nxt;
      dsq7_r  <= dsq7_nxt;
    end
  end

  sbc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_v     (v7_r),
    .in_x     (dsq7_r),
    .in_ctx   (c7_r),
    .out_v    (sq_v),
    .out_root (sq_root),
    .out_ctx  (sq_ctx)
  );

  sbc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_v     (sq_v),
    .in_dist  (sq_root),
    .in_ctx   (sq_ctx),
    .out_v    (dv_v),
    .out_dist (dv_dist),
    .out_ctx  (dv_ctx),
    .out_q    (dv_q)
  );

  // W1: pick the local normal and rotate it back, one product per entry
  always_comb begin
    logic [2:0]         ax_sel;
    logic signed [15:0] nl [3];
    logic signed [15:0] qs;
    ax_sel[0] = dv_ctx.axis == sbc_pkg::AX_X;
    ax_sel[1] = dv_ctx.axis == sbc_pkg::AX_Y;
    ax_sel[2] = dv_ctx.axis == sbc_pkg::AX_Z;
    for (int j = 0; j < 3; j++) begin
      qs = $signed({1'b0, dv_q[j]});
      if (dv_dist == '0) begin
        nl[j] = ax_sel[j] ? (dv_ctx.apos ? sbc_pkg::NORM_ONE : -sbc_pkg::NORM_ONE) : '0;
      end else begin
        nl[j] = dv_ctx.neg[j] ? -qs : qs;
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        wp1_nxt[i*3+j] = $signed(dv_ctx.m[i*3+j]) * nl[j];
      end
    end
  end

  // W2: sum, round to Q2.14 and saturate
  always_comb begin
    logic signed [43:0] acc;
    logic signed [23:0] rr;
    for (int i = 0; i < 3; i++) begin
      acc = 44'(wp1_r[i*3]) + 44'(wp1_r[i*3+1]) + 44'(wp1_r[i*3+2]) + (44'sd1 <<< 19);
      rr  = $signed(acc[43:20]);
      if (rr > NW_MAX) begin
        nw2_nxt[i] = sbc_pkg::NORM_ONE;
      end else if (rr < -NW_MAX) begin
        nw2_nxt[i] = -sbc_pkg::NORM_ONE;
      end else begin
        nw2_nxt[i] = 16'(rr);
      end
    end
  end

  // P1: normal times radius, penetration
  always_comb begin
    logic [31:0] pd;
    for (int i = 0; i < 3; i++) pr1_nxt[i] = nw2_r[i] * $signed({1'b0, w2_c_r.r});
    pd       = {1'b0, w2_c_r.r} - w2_dist_r;
    pen1_nxt = pd[30:0];
  end

  // Result: contact point, saturation, zero fields on a miss
  always_comb begin
    logic signed [47:0] t;
    logic signed [34:0] pt;
    logic signed [31:0] ps [3];
    for (int i = 0; i < 3; i++) begin
      t  = pr1_r[i] + 48'sd8192;
      pt = 35'($signed(p1_c_r.s[i])) - 35'($signed(t[47:14]));
      if (pt > PT_MAX) begin
        ps[i] = 32'(PT_MAX);
      end else if (pt < PT_MIN) begin
        ps[i] = 32'(PT_MIN);
      end else begin
        ps[i] = 32'(pt);
      end
    end
    out_data_nxt = '0;
    if (!p1_c_r.miss) begin
      out_data_nxt.hit         = 1'b1;
      out_data_nxt.normal_x    = nwp1_r[0];
      out_data_nxt.normal_y    = nwp1_r[1];
      out_data_nxt.normal_z    = nwp1_r[2];
      out_data_nxt.penetration = pen1_r;
      out_data_nxt.point_x     = ps[0];
      out_data_nxt.point_y     = ps[1];
      out_data_nxt.point_z     = ps[2];
    end
  end

  // Advance valid bits of the back stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_v_r      <= 1'b0;
      w2_v_r      <= 1'b0;
      p1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      w1_v_r      <= dv_v;
      w2_v_r      <= w1_v_r;
      p1_v_r      <= w2_v_r;
      out_valid_r <= p1_v_r;
    end
  end

  // Advance payload of the back stages
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      w1_c_r     <= dv_ctx;
      w1_dist_r  <= dv_dist;
      wp1_r      <= wp1_nxt;
      w2_c_r     <= w1_c_r;
      w2_dist_r  <= w1_dist_r;
      nw2_r      <= nw2_nxt;
      p1_c_r     <= w2_c_r;
      pr1_r      <= pr1_nxt;
      nwp1_r     <= nw2_r;
      pen1_r     <= pen1_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  `SBC_ASSERT_IMP(a_miss_zero, out_valid_r && !out_data_r.hit, out_data_r.penetration == '0 && out_data_r.point_x == '0 && out_data_r.normal_x == '0)
  `SBC_ASSERT_IMP(a_hit_depth, out_valid_r && out_data_r.hit, out_data_r.penetration != '0)
  `SBC_ASSERT_IMP(a_norm_range, out_valid_r && out_data_r.hit, out_data_r.normal_x <= sbc_pkg::NORM_ONE && out_data_r.normal_x >= -sbc_pkg::NORM_ONE && out_data_r.normal_z <= sbc_pkg::NORM_ONE && out_data_r.normal_z >= -sbc_pkg::NORM_ONE)
  `SBC_ASSERT_NXT(a_stall_hold, !pipe_en, $stable(dsq7_r) && $stable(v7_r) && $stable(w1_v_r))

endmodule

`default_nettype wire
